>>> src/csfp_pkg.sv
// Package for the checked sensor frame parser.
// Holds frame layout constants, status codes and the byte-wide CRC-16 update.
// Used by the top level and by its port checker.
package csfp_pkg;

    typedef logic [1:0]  status_t;
    typedef logic [6:0]  pos_t;
    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;

    // Status codes of a result item.
    localparam status_t STATUS_OK          = 2'd0;
    localparam status_t STATUS_TOO_SHORT   = 2'd1;
    localparam status_t STATUS_WRONG_START = 2'd2;
    localparam status_t STATUS_CRC_ERROR   = 2'd3;

    // Framing bytes and CRC polynomial.
    localparam byte_t ACK_CODE   = 8'h06;
    localparam byte_t START_CODE = 8'h4C;
    localparam word_t CRC_POLY   = 16'h1021;

    // Frame layout, in frame byte offsets.
    localparam pos_t CRC_HIGH_POS = 7'd97;
    localparam pos_t CRC_LOW_POS  = 7'd98;
    localparam pos_t HUMIDITY_POS = 7'd33;
    localparam pos_t DAY_RAIN_POS = 7'd50;
    localparam pos_t POS_MAX      = 7'd127;

    // A frame needs frame bytes 0 to 98; the buffer position of its last byte.
    localparam pos_t LAST_NEEDED_POS = 7'd98;

    localparam int NUM_WORDS = 7;
    localparam pos_t WORD_OFFSET [NUM_WORDS] = '{7'd7, 7'd9, 7'd12, 7'd16,
                                                 7'd18, 7'd20, 7'd22};

    // One byte of CRC-16, MSB first, no reflection.
    function automatic word_t crc16_byte(input word_t crc, input byte_t d);
        word_t c;
        c = crc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/crc16_checked_sensor_frame_parser_unit.sv
// Top level of the checked sensor frame parser.
// Depends on csfp_pkg for frame constants, status codes and the CRC update.
//
// Usage:
// The input channel (in_valid, in_stall, data_byte, last_byte) takes one byte
// of a received buffer per item; last_byte marks the final byte. A leading
// ACK byte followed by 'L' is dropped, otherwise the frame must start with
// 'L'. The CRC-16 over frame bytes 0 to 96 is checked against the big-endian
// CRC in bytes 97 and 98, and the weather fields are captured at fixed
// offsets.
// The output channel (out_valid, out_stall and the status and field ports)
// gives one result item per buffer, on its last byte. Fields read zero
// unless status is ok.
// Throughput is one byte per cycle unless stalled: each byte passes an input
// register, then one CRC byte update and field capture into the parse state
// and the result register, which sets out_valid on a last byte. Reset clears
// both valid flags and the parse state but for the captured fields. While the
// receiver stalls, the result holds; non-last bytes keep flowing, and only a
// second last byte waits in the input register, which then raises in_stall.
module crc16_checked_sensor_frame_parser_unit
    import csfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] barometer,
    output logic [15:0] room_temp,
    output logic [15:0] air_temp,
    output logic [15:0] wind_bearing,
    output logic [15:0] wind_avg_ten_minutes,
    output logic [15:0] wind_avg_two_minutes,
    output logic [15:0] wind_gust_ten_minutes,
    output logic [7:0]  air_humidity,
    output logic [7:0]  day_rain_low
);

    // Input register.
    logic  s1_valid_reg;
    byte_t s1_data_reg;
    logic  s1_last_reg;

    // Parse state.
    pos_t  pos_reg, pos_next;
    logic  ack_reg, ack_next;
    logic  serr_reg, serr_next;
    word_t crc_reg, crc_next;
    byte_t crc_high_reg, crc_high_next;
    word_t words_reg [NUM_WORDS];
    word_t words_next [NUM_WORDS];
    byte_t humidity_reg, humidity_next;
    byte_t rain_reg, rain_next;

    // Result register.
    logic    out_valid_reg;
    status_t status_reg;
    word_t   out_words_reg [NUM_WORDS];
    byte_t   out_humidity_reg;
    byte_t   out_rain_reg;

    logic    out_free;
    logic    s1_done;
    logic    out_load;
    logic    do_frame;
    pos_t    fi;
    logic    too_short;
    status_t status_next;

    // Handshake: a non-last item always proceeds, a last one needs room.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_done  = !s1_last_reg || out_free;
    assign in_stall = s1_valid_reg && !s1_done;
    assign out_load = s1_valid_reg && s1_last_reg && out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Start detection and the frame offset of the current byte.
    always_comb
    begin
        ack_next  = ack_reg;
        serr_next = serr_reg;
        do_frame  = 1'b0;
        fi        = pos_reg;
        if (pos_reg == '0)
        begin
            if (s1_data_reg == ACK_CODE)
            begin
                ack_next = 1'b1;
            end
            else
            begin
                serr_next = (s1_data_reg != START_CODE);
                do_frame  = 1'b1;
            end
        end
        else if (ack_reg)
        begin
            if (pos_reg == 7'd1 && s1_data_reg != START_CODE)
            begin
                ack_next  = 1'b0;
                serr_next = 1'b1;
            end
            else
            begin
                do_frame = 1'b1;
                fi       = pos_reg - 7'd1;
            end
        end
        else
        begin
            do_frame = 1'b1;
        end
    end

    // CRC update and field capture for one frame byte.
    always_comb
    begin
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        humidity_next = humidity_reg;
        rain_next     = rain_reg;
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            words_next[k] = words_reg[k];
        end
        if (do_frame)
        begin
            if (fi < CRC_HIGH_POS)
            begin
                crc_next = crc16_byte(crc_reg, s1_data_reg);
            end
            else if (fi == CRC_HIGH_POS)
            begin
                crc_high_next = s1_data_reg;
            end
            else if (fi == CRC_LOW_POS)
            begin
                crc_next = crc_reg ^ {crc_high_reg, s1_data_reg};
            end
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                if (fi == WORD_OFFSET[k])
                begin
                    words_next[k] = {words_reg[k][15:8], s1_data_reg};
                end
                else if (fi == WORD_OFFSET[k] + 7'd1)
                begin
                    words_next[k] = {s1_data_reg, words_reg[k][7:0]};
                end
            end
            if (fi == HUMIDITY_POS)
            begin
                humidity_next = s1_data_reg;
            end
            if (fi == DAY_RAIN_POS)
            begin
                rain_next = s1_data_reg;
            end
        end
        pos_next = (pos_reg != POS_MAX) ? pos_reg + 7'd1 : pos_reg;
    end

    // Status of the buffer when this byte is the last one.
    assign too_short = (pos_reg < LAST_NEEDED_POS) ||
                       (ack_next && pos_reg == LAST_NEEDED_POS);

    always_comb
    begin
        if (too_short)
        begin
            status_next = STATUS_TOO_SHORT;
        end
        else if (serr_next)
        begin
            status_next = STATUS_WRONG_START;
        end
        else if (crc_next != '0)
        begin
            status_next = STATUS_CRC_ERROR;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    // Parse state control; the last byte returns it to the start of a buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            ack_reg      <= 1'b0;
            serr_reg     <= 1'b0;
            crc_reg      <= '0;
            crc_high_reg <= '0;
        end
        else if (s1_valid_reg && s1_done)
        begin
            if (s1_last_reg)
            begin
                pos_reg      <= '0;
                ack_reg      <= 1'b0;
                serr_reg     <= 1'b0;
                crc_reg      <= '0;
                crc_high_reg <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                ack_reg      <= ack_next;
                serr_reg     <= serr_next;
                crc_reg      <= crc_next;
                crc_high_reg <= crc_high_next;
            end
        end
    end

    // Captured fields; an ok frame rewrites every one of them.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_done)
        begin
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                words_reg[k] <= words_next[k];
            end
            humidity_reg <= humidity_next;
            rain_reg     <= rain_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; fields are zero unless the frame checked out.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= status_next;
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                out_words_reg[k] <= (status_next == STATUS_OK) ? words_next[k] : '0;
            end
            out_humidity_reg <= (status_next == STATUS_OK) ? humidity_next : '0;
            out_rain_reg     <= (status_next == STATUS_OK) ? rain_next : '0;
        end
    end

    assign out_valid             = out_valid_reg;
    assign status                = status_reg;
    assign barometer             = out_words_reg[0];
    assign room_temp             = out_words_reg[1];
    assign air_temp              = out_words_reg[2];
    assign wind_bearing          = out_words_reg[3];
    assign wind_avg_ten_minutes  = out_words_reg[4];
    assign wind_avg_two_minutes  = out_words_reg[5];
    assign wind_gust_ten_minutes = out_words_reg[6];
    assign air_humidity          = out_humidity_reg;
    assign day_rain_low          = out_rain_reg;

endmodule

>>> src/csfp_checker.sv
// Port checker for the checked sensor frame parser, and its bind.
// Depends on csfp_pkg for the status codes.
module csfp_checker
    import csfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [15:0] barometer,
    input logic [15:0] wind_gust_ten_minutes,
    input logic [7:0]  air_humidity,
    input logic [7:0]  day_rain_low
);

    // A held result stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A held result keeps its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status))
        else $error("status changed while stalled");

    // The input side only waits behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // A failed frame carries zero barometer, gust, humidity and rain fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |->
            barometer == '0 && wind_gust_ten_minutes == '0 &&
            air_humidity == '0 && day_rain_low == '0)
        else $error("fields not cleared on a failed frame");

endmodule

bind crc16_checked_sensor_frame_parser_unit csfp_checker u_csfp_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_stall              (in_stall),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .status                (status),
    .barometer             (barometer),
    .wind_gust_ten_minutes (wind_gust_ten_minutes),
    .air_humidity          (air_humidity),
    .day_rain_low          (day_rain_low)
);

>>> tb/sv/crc16_checked_sensor_frame_parser_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for crc16_checked_sensor_frame_parser_unit.
// Feeds whole buffers byte by byte, predicts each buffer's report and checks the outputs.
// Depends on csfp_pkg and the top-level RTL only.
module crc16_checked_sensor_frame_parser_unit_test;
    import csfp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 600;
    localparam int MAX_SHOWN     = 10;
    localparam int FRAME_BYTES   = 99;
    localparam int CRC_SPAN      = 97;
    localparam int NUM_BUF_KINDS = 9;
    localparam int HUM_AT        = 33;
    localparam int RAIN_AT       = 50;
    localparam int WORD_AT [7]   = '{7, 9, 12, 16, 18, 20, 22};

    // Shapes of buffer that the stimulus builds.
    typedef enum int {
        BUF_PLAIN,
        BUF_ACKED,
        BUF_CRC_HIT,
        BUF_TRUNCATED,
        BUF_BAD_START,
        BUF_ACK_NO_L,
        BUF_TRAILING,
        BUF_OVERLONG,
        BUF_NOISE
    } buf_kind_t;

    typedef struct packed {
        byte_t value;
        logic  is_last;
    } feed_item_t;

    typedef struct packed {
        status_t         st;
        word_t [6:0]     words;
        byte_t           humidity;
        byte_t           rain;
    } frame_report_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] barometer;
    logic [15:0] room_temp;
    logic [15:0] air_temp;
    logic [15:0] wind_bearing;
    logic [15:0] wind_avg_ten_minutes;
    logic [15:0] wind_avg_two_minutes;
    logic [15:0] wind_gust_ten_minutes;
    logic [7:0]  air_humidity;
    logic [7:0]  day_rain_low;

    crc16_checked_sensor_frame_parser_unit dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .data_byte             (data_byte),
        .last_byte             (last_byte),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .status                (status),
        .barometer             (barometer),
        .room_temp             (room_temp),
        .air_temp              (air_temp),
        .wind_bearing          (wind_bearing),
        .wind_avg_ten_minutes  (wind_avg_ten_minutes),
        .wind_avg_two_minutes  (wind_avg_two_minutes),
        .wind_gust_ten_minutes (wind_gust_ten_minutes),
        .air_humidity          (air_humidity),
        .day_rain_low          (day_rain_low)
    );

    // Bytes waiting to be sent and reports waiting to be received.
    feed_item_t    byte_feed [$];
    frame_report_t expected_reports [$];

    // Parser state as the predictor sees it.
    logic [6:0] buf_pos;
    bit         ack_seen;
    bit         bad_start;
    word_t      crc_acc;
    byte_t      crc_high_rx;
    word_t      cap_words [7];
    byte_t      cap_humidity;
    byte_t      cap_rain;

    int  errors       = 0;
    int  results_seen = 0;
    int  cycles       = 0;
    bit  byte_taken   = 1'b0;
    bit  hold_off     = 1'b0;
    int  burst_left   = 1;
    int  gap_left     = 0;
    int  stall_mode   = 0;
    int  mode_left    = 0;
    int  stall_phase  = 0;
    bit  stall_bit;
    feed_item_t    feed_item;
    frame_report_t got_report;
    frame_report_t want_report;

    // CRC-16 with polynomial 0x1021, one data bit at a time, MSB first.
    function automatic word_t next_crc(input word_t crc, input byte_t d);
        word_t c;
        logic  fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic clear_parse_state;
        buf_pos      = '0;
        ack_seen     = 1'b0;
        bad_start    = 1'b0;
        crc_acc      = '0;
        crc_high_rx  = '0;
        cap_humidity = '0;
        cap_rain     = '0;
        for (int k = 0; k < 7; k++)
        begin
            cap_words[k] = '0;
        end
    endtask

    // One byte at a given frame offset: CRC, received CRC and field capture.
    task automatic take_frame_byte(input int fi, input byte_t d);
        if (fi < CRC_SPAN)
        begin
            crc_acc = next_crc(crc_acc, d);
        end
        else if (fi == CRC_SPAN)
        begin
            crc_high_rx = d;
        end
        else if (fi == CRC_SPAN + 1)
        begin
            crc_acc = crc_acc ^ {crc_high_rx, d};
        end
        for (int k = 0; k < 7; k++)
        begin
            if (fi == WORD_AT[k])
            begin
                cap_words[k][7:0] = d;
            end
            else if (fi == WORD_AT[k] + 1)
            begin
                cap_words[k][15:8] = d;
            end
        end
        if (fi == HUM_AT)
        begin
            cap_humidity = d;
        end
        if (fi == RAIN_AT)
        begin
            cap_rain = d;
        end
    endtask

    // Advance the parser by one accepted byte; a last byte yields a report.
    task automatic absorb_byte(input byte_t d, input logic is_last);
        int            pos;
        int            need;
        frame_report_t rep;
        pos = buf_pos;
        if (pos == 0)
        begin
            if (d == ACK_CODE)
            begin
                ack_seen = 1'b1;
            end
            else
            begin
                bad_start = (d != START_CODE);
                take_frame_byte(0, d);
            end
        end
        else if (ack_seen)
        begin
            // An ACK not followed by the start byte is a wrong start.
            if (pos == 1 && d != START_CODE)
            begin
                ack_seen  = 1'b0;
                bad_start = 1'b1;
            end
            else
            begin
                take_frame_byte(pos - 1, d);
            end
        end
        else
        begin
            take_frame_byte(pos, d);
        end
        if (buf_pos != POS_MAX)
        begin
            buf_pos = buf_pos + 7'd1;
        end
        if (is_last)
        begin
            need = FRAME_BYTES + (ack_seen ? 1 : 0);
            rep  = '0;
            if (pos + 1 < need)
            begin
                rep.st = STATUS_TOO_SHORT;
            end
            else if (bad_start)
            begin
                rep.st = STATUS_WRONG_START;
            end
            else if (crc_acc != '0)
            begin
                rep.st = STATUS_CRC_ERROR;
            end
            else
            begin
                rep.st = STATUS_OK;
                for (int k = 0; k < 7; k++)
                begin
                    rep.words[k] = cap_words[k];
                end
                rep.humidity = cap_humidity;
                rep.rain     = cap_rain;
            end
            expected_reports.push_back(rep);
            clear_parse_state();
        end
    endtask

    task automatic flag_error(input string what, input int unsigned want, input int unsigned got);
        errors++;
        if (errors <= MAX_SHOWN)
        begin
            $display("mismatch in %s on report %0d: expected %h, got %h",
                     what, results_seen, want, got);
        end
    endtask

    task automatic feed_byte(input byte_t d, input logic is_last);
        feed_item_t it;
        it.value   = d;
        it.is_last = is_last;
        byte_feed.push_back(it);
    endtask

    function automatic buf_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)      return BUF_PLAIN;
        else if (r < 45) return BUF_ACKED;
        else if (r < 55) return BUF_CRC_HIT;
        else if (r < 65) return BUF_TRUNCATED;
        else if (r < 70) return BUF_BAD_START;
        else if (r < 78) return BUF_ACK_NO_L;
        else if (r < 86) return BUF_TRAILING;
        else if (r < 92) return BUF_OVERLONG;
        else             return BUF_NOISE;
    endfunction

    // Build one buffer around a correct frame with random content, then bend it.
    task automatic queue_buffer(input buf_kind_t kind);
        byte_t img [$];
        word_t crc;
        byte_t x;
        int    n;
        int    i;
        img.push_back(START_CODE);
        for (i = 1; i < CRC_SPAN; i++)
        begin
            img.push_back(byte_t'($urandom_range(0, 255)));
        end
        crc = '0;
        for (i = 0; i < CRC_SPAN; i++)
        begin
            crc = next_crc(crc, img[i]);
        end
        img.push_back(crc[15:8]);
        img.push_back(crc[7:0]);
        case (kind)
            BUF_ACKED:
            begin
                img.push_front(ACK_CODE);
            end
            BUF_CRC_HIT:
            begin
                i = $urandom_range(1, FRAME_BYTES - 1);
                img[i] = img[i] ^ byte_t'($urandom_range(1, 255));
                if ($urandom_range(0, 1))
                begin
                    img.push_front(ACK_CODE);
                end
            end
            BUF_TRUNCATED:
            begin
                if ($urandom_range(0, 1))
                begin
                    img.push_front(ACK_CODE);
                end
                // Often one byte short, which is the hardest length to get right.
                n = ($urandom_range(0, 2) == 0) ? img.size() - 1
                                                : $urandom_range(1, img.size() - 1);
                while (img.size() > n)
                begin
                    void'(img.pop_back());
                end
            end
            BUF_BAD_START:
            begin
                do
                begin
                    x = byte_t'($urandom_range(0, 255));
                end
                while (x == START_CODE || x == ACK_CODE);
                img[0] = x;
            end
            BUF_ACK_NO_L:
            begin
                do
                begin
                    x = byte_t'($urandom_range(0, 255));
                end
                while (x == START_CODE);
                img[0] = x;
                img.push_front(ACK_CODE);
                n = $urandom_range(0, 2);
                for (i = 0; i < n; i++)
                begin
                    void'(img.pop_back());
                end
            end
            BUF_TRAILING, BUF_OVERLONG:
            begin
                if ($urandom_range(0, 1))
                begin
                    img.push_front(ACK_CODE);
                end
                n = (kind == BUF_TRAILING) ? $urandom_range(1, 20) : $urandom_range(30, 80);
                for (i = 0; i < n; i++)
                begin
                    img.push_back(byte_t'($urandom_range(0, 255)));
                end
            end
            BUF_NOISE:
            begin
                img.delete();
                n = $urandom_range(1, 120);
                for (i = 0; i < n; i++)
                begin
                    img.push_back(byte_t'($urandom_range(0, 255)));
                end
                case ($urandom_range(0, 2))
                    0: img[0] = ACK_CODE;
                    1: img[0] = START_CODE;
                    default: ;
                endcase
            end
            default: ;
        endcase
        for (i = 0; i < img.size(); i++)
        begin
            feed_byte(img[i], i == img.size() - 1);
        end
    endtask

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: take accepted bytes into the predictor, check each report.
    always @(posedge clk)
    begin
        byte_taken = rst_n && in_valid && !in_stall;
        if (byte_taken)
        begin
            absorb_byte(data_byte, last_byte);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            got_report.st       = status;
            got_report.words[0] = barometer;
            got_report.words[1] = room_temp;
            got_report.words[2] = air_temp;
            got_report.words[3] = wind_bearing;
            got_report.words[4] = wind_avg_ten_minutes;
            got_report.words[5] = wind_avg_two_minutes;
            got_report.words[6] = wind_gust_ten_minutes;
            got_report.humidity = air_humidity;
            got_report.rain     = day_rain_low;
            if (expected_reports.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                begin
                    $display("report %0d arrived with none expected, status %0d",
                             results_seen, status);
                end
            end
            else
            begin
                want_report = expected_reports.pop_front();
                if (got_report.st != want_report.st)
                    flag_error("status", want_report.st, got_report.st);
                if (got_report.words[0] != want_report.words[0])
                    flag_error("barometer", want_report.words[0], got_report.words[0]);
                if (got_report.words[1] != want_report.words[1])
                    flag_error("room_temp", want_report.words[1], got_report.words[1]);
                if (got_report.words[2] != want_report.words[2])
                    flag_error("air_temp", want_report.words[2], got_report.words[2]);
                if (got_report.words[3] != want_report.words[3])
                    flag_error("wind_bearing", want_report.words[3], got_report.words[3]);
                if (got_report.words[4] != want_report.words[4])
                    flag_error("wind_avg_ten_minutes", want_report.words[4], got_report.words[4]);
                if (got_report.words[5] != want_report.words[5])
                    flag_error("wind_avg_two_minutes", want_report.words[5], got_report.words[5]);
                if (got_report.words[6] != want_report.words[6])
                    flag_error("wind_gust_ten_minutes", want_report.words[6], got_report.words[6]);
                if (got_report.humidity != want_report.humidity)
                    flag_error("air_humidity", want_report.humidity, got_report.humidity);
                if (got_report.rain != want_report.rain)
                    flag_error("day_rain_low", want_report.rain, got_report.rain);
            end
        end
    end

    // Driver: present the next byte once the current one is taken, in bursts with gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || byte_taken))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (byte_feed.size() != 0)
            begin
                feed_item = byte_feed.pop_front();
                in_valid  <= 1'b1;
                data_byte <= feed_item.value;
                last_byte <= feed_item.is_last;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                             : $urandom_range(1, 24);
                    gap_left   = $urandom_range(0, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that switches between modes every so often.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(40, 300);
        end
        else
        begin
            mode_left--;
        end
        stall_phase++;
        case (stall_mode)
            0:       stall_bit = 1'b0;
            1:       stall_bit = $urandom_range(0, 1);
            2:       stall_bit = (stall_phase % 7) < 3;
            default: stall_bit = ($urandom_range(0, 9) != 0);
        endcase
        out_stall <= hold_off || stall_bit;
    end

    // One long receiver hold-off so that a second last byte backs up the input.
    initial
    begin
        while (results_seen < 4)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        hold_off = 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++)
        begin
            @(posedge clk);
        end
        hold_off = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        word_t known;
        int    guard;
        clear_parse_state();

        // Known answer of this CRC over the ASCII digits one to nine.
        known = '0;
        for (int i = 1; i <= 9; i++)
        begin
            known = next_crc(known, byte_t'(8'h30 + i));
        end
        if (known != 16'h31C3)
        begin
            flag_error("CRC known answer", 16'h31C3, known);
        end

        // Directed short buffers: extreme bytes, lone ACK and start bytes.
        feed_byte(8'h00, 1'b1);
        feed_byte(8'hFF, 1'b1);
        feed_byte(ACK_CODE, 1'b1);
        feed_byte(START_CODE, 1'b1);
        feed_byte(ACK_CODE, 1'b0);
        feed_byte(START_CODE, 1'b1);
        feed_byte(ACK_CODE, 1'b0);
        feed_byte(8'h00, 1'b1);
        feed_byte(START_CODE, 1'b0);
        feed_byte(8'hFF, 1'b0);
        feed_byte(8'h00, 1'b1);
        feed_byte(8'h55, 1'b0);
        feed_byte(8'hAA, 1'b1);

        // Random buffers: every shape once first, then a weighted mix.
        for (int b = 0; byte_feed.size() < 2000 || b < NUM_BUF_KINDS; b++)
        begin
            queue_buffer(b < NUM_BUF_KINDS ? buf_kind_t'(b) : pick_kind());
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (byte_feed.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        guard = 0;
        while (expected_reports.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            errors++;
            $display("%0d expected reports never arrived", expected_reports.size());
        end

        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
